>>> rtl/core/csf_pkg.sv
// Shared widths, register codes, result type and helpers for the cross sharpen filter.
package csf_pkg;

	localparam int CFG_W  = 12;
	localparam int CH_W   = 3;
	localparam int PIX_W  = 8;
	localparam int ROW_W  = 11;
	localparam int IDX_W  = 13;
	localparam int ACC_W  = 12;
	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;

	localparam int MIN_DIM     = 3;
	localparam int MIN_CH      = 1;
	localparam int CENTRE_GAIN = 5;

	localparam int WIDTH_RST    = 640;
	localparam int HEIGHT_RST   = 480;
	localparam int CHANNELS_RST = 1;

	typedef enum logic [1:0] {
		REG_WIDTH    = 2'd0,
		REG_HEIGHT   = 2'd1,
		REG_CHANNELS = 2'd2
	} reg_idx_t;

	// Up to two results for one input item: the row above, then the last row.
	typedef struct packed {
		logic [ROW_W-1:0] row_a;
		logic [ROW_W-1:0] row_b;
		logic [IDX_W-1:0] idx;
		logic [PIX_W-1:0] value;
		logic             two;
		logic             last;
	} result_pair_t;

	function automatic int clamp_int(input int v, input int lo, input int hi);
		int r;
		r = v;
		if (v < lo) begin
			r = lo;
		end else if (v > hi) begin
			r = hi;
		end
		return r;
	endfunction

endpackage

>>> rtl/core/csf_in_if.sv
// Input sample channel: valid/ready handshake carrying one 8-bit sample.
interface csf_in_if;
	logic                       valid;
	logic                       ready;
	logic [csf_pkg::PIX_W-1:0]  sample_value;

	modport source(output valid, output sample_value, input ready);
	modport sink(input valid, input sample_value, output ready);
endinterface

>>> rtl/core/csf_out_if.sv
// Result channel: valid/ready handshake carrying position, value and frame end.
interface csf_out_if;
	logic                       valid;
	logic                       ready;
	logic [csf_pkg::ROW_W-1:0]  out_row;
	logic [csf_pkg::IDX_W-1:0]  out_sample_index;
	logic [csf_pkg::PIX_W-1:0]  out_value;
	logic                       frame_last;

	modport source(output valid, output out_row, output out_sample_index,
		output out_value, output frame_last, input ready);
	modport sink(input valid, input out_row, input out_sample_index,
		input out_value, input frame_last, output ready);
endinterface

>>> rtl/core/csf_cfg_regs.sv
// APB register file: frame geometry, with clamped working values kept ready.
module csf_cfg_regs #(
	parameter int MAX_WIDTH    = 2048,
	parameter int MAX_HEIGHT   = 2048,
	parameter int MAX_CHANNELS = 4,
	localparam int DEPTH = MAX_WIDTH * MAX_CHANNELS,
	localparam int AW    = $clog2(DEPTH)
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [csf_pkg::ADDR_W-1:0]   paddr,
	input  logic [csf_pkg::DATA_W-1:0]   pwdata,
	output logic [csf_pkg::DATA_W-1:0]   prdata,
	output logic                         pready,
	output logic [csf_pkg::CH_W-1:0]     chan,
	output logic [csf_pkg::CFG_W-1:0]    row_last,
	output logic [AW-1:0]                x_last,
	output logic [AW-1:0]                x_right,
	output logic                         restart
);
	localparam int LW  = $clog2(DEPTH + 1);
	localparam int MW  = csf_pkg::CFG_W + csf_pkg::CH_W;

	localparam int W_EFF_RST = csf_pkg::clamp_int(csf_pkg::WIDTH_RST, csf_pkg::MIN_DIM, MAX_WIDTH);
	localparam int H_EFF_RST = csf_pkg::clamp_int(csf_pkg::HEIGHT_RST, csf_pkg::MIN_DIM,
		MAX_HEIGHT);
	localparam int C_EFF_RST = csf_pkg::clamp_int(csf_pkg::CHANNELS_RST, csf_pkg::MIN_CH,
		MAX_CHANNELS);
	localparam int LEN_RST = W_EFF_RST * C_EFF_RST;

	csf_pkg::reg_idx_t           idx;
	logic                        wr;
	logic                        hit;
	logic [csf_pkg::CFG_W-1:0]   width_q, height_q;
	logic [csf_pkg::CH_W-1:0]    chan_raw_q;
	logic [csf_pkg::CFG_W-1:0]   width_nx, height_nx;
	logic [csf_pkg::CH_W-1:0]    chan_nx;
	logic [csf_pkg::CFG_W-1:0]   w_eff_nx, h_eff_nx;
	logic [csf_pkg::CH_W-1:0]    c_eff_nx;
	logic [MW-1:0]               len_full;
	logic [LW-1:0]               len_nx;
	logic [csf_pkg::CH_W-1:0]    chan_q;
	logic [csf_pkg::CFG_W-1:0]   row_last_q;
	logic [AW-1:0]               x_last_q, x_right_q;

	assign idx    = csf_pkg::reg_idx_t'(paddr[3:2]);
	assign wr     = psel & penable & pwrite;
	assign pready = 1'b1;

	always_comb begin
		width_nx  = width_q;
		height_nx = height_q;
		chan_nx   = chan_raw_q;
		hit       = 1'b0;
		prdata    = '0;
		unique case (idx)
			csf_pkg::REG_WIDTH: begin
				hit      = 1'b1;
				width_nx = pwdata[csf_pkg::CFG_W-1:0];
				prdata   = csf_pkg::DATA_W'(width_q);
			end
			csf_pkg::REG_HEIGHT: begin
				hit       = 1'b1;
				height_nx = pwdata[csf_pkg::CFG_W-1:0];
				prdata    = csf_pkg::DATA_W'(height_q);
			end
			csf_pkg::REG_CHANNELS: begin
				hit     = 1'b1;
				chan_nx = pwdata[csf_pkg::CH_W-1:0];
				prdata  = csf_pkg::DATA_W'(chan_raw_q);
			end
			default: begin
				hit = 1'b0;
			end
		endcase
	end

	assign restart = wr & hit;

	// Working values follow from the register set as it stands after this write.
	assign w_eff_nx = csf_pkg::CFG_W'(csf_pkg::clamp_int(int'(width_nx), csf_pkg::MIN_DIM,
		MAX_WIDTH));
	assign h_eff_nx = csf_pkg::CFG_W'(csf_pkg::clamp_int(int'(height_nx), csf_pkg::MIN_DIM,
		MAX_HEIGHT));
	assign c_eff_nx = csf_pkg::CH_W'(csf_pkg::clamp_int(int'(chan_nx), csf_pkg::MIN_CH,
		MAX_CHANNELS));
	assign len_full = MW'(w_eff_nx) * MW'(c_eff_nx);
	assign len_nx   = LW'(len_full);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q    <= csf_pkg::CFG_W'(csf_pkg::WIDTH_RST);
			height_q   <= csf_pkg::CFG_W'(csf_pkg::HEIGHT_RST);
			chan_raw_q <= csf_pkg::CH_W'(csf_pkg::CHANNELS_RST);
			chan_q     <= csf_pkg::CH_W'(C_EFF_RST);
			row_last_q <= csf_pkg::CFG_W'(H_EFF_RST - 1);
			x_last_q   <= AW'(LEN_RST - 1);
			x_right_q  <= AW'(LEN_RST - C_EFF_RST);
		end else if (restart) begin
			width_q    <= width_nx;
			height_q   <= height_nx;
			chan_raw_q <= chan_nx;
			chan_q     <= c_eff_nx;
			row_last_q <= h_eff_nx - csf_pkg::CFG_W'(1);
			x_last_q   <= AW'(len_nx - LW'(1));
			x_right_q  <= AW'(len_nx - LW'(c_eff_nx));
		end
	end

	assign chan     = chan_q;
	assign row_last = row_last_q;
	assign x_last   = x_last_q;
	assign x_right  = x_right_q;

endmodule

>>> rtl/core/csf_line_mem.sv
// Two line memories: recent row (two read ports) and older row, with registered reads.
module csf_line_mem #(
	parameter int DEPTH = 8192,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic                        clk,
	input  logic                        acc_en,
	input  logic [AW-1:0]               acc_addr,
	input  logic [AW-1:0]               acc_right_addr,
	input  logic [csf_pkg::PIX_W-1:0]   acc_sample,
	input  logic                        older_wr_en,
	input  logic [AW-1:0]               older_wr_addr,
	input  logic [csf_pkg::PIX_W-1:0]   older_wr_data,
	output logic [csf_pkg::PIX_W-1:0]   centre,
	output logic [csf_pkg::PIX_W-1:0]   right_px,
	output logic [csf_pkg::PIX_W-1:0]   above
);
	logic [csf_pkg::PIX_W-1:0] recent_line_q [DEPTH];
	logic [csf_pkg::PIX_W-1:0] older_line_q  [DEPTH];
	logic [csf_pkg::PIX_W-1:0] centre_q, right_q, above_q;

	// Read old contents and store the new sample at the same address.
	always_ff @(posedge clk) begin
		if (acc_en) begin
			centre_q                <= recent_line_q[acc_addr];
			right_q                 <= recent_line_q[acc_right_addr];
			recent_line_q[acc_addr] <= acc_sample;
		end
	end

	always_ff @(posedge clk) begin
		if (acc_en) begin
			above_q <= older_line_q[acc_addr];
		end
		if (older_wr_en) begin
			older_line_q[older_wr_addr] <= older_wr_data;
		end
	end

	assign centre   = centre_q;
	assign right_px = right_q;
	assign above    = above_q;

endmodule

>>> rtl/core/csf_emit.sv
// Output register: holds one item's results and presents them one at a time.
module csf_emit (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   load_valid,
	output logic                   load_ready,
	input  csf_pkg::result_pair_t  load_pair,
	csf_out_if.source              results
);
	csf_pkg::result_pair_t pair_q;
	logic                  valid_q;
	logic                  phase_q;
	logic                  done;

	assign done       = valid_q & results.ready & (phase_q | ~pair_q.two);
	assign load_ready = ~valid_q | done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			phase_q <= 1'b0;
		end else if (load_valid && load_ready) begin
			valid_q <= 1'b1;
			phase_q <= 1'b0;
		end else if (done) begin
			valid_q <= 1'b0;
		end else if (valid_q && results.ready) begin
			phase_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_valid && load_ready) begin
			pair_q <= load_pair;
		end
	end

	assign results.valid            = valid_q;
	assign results.out_row          = phase_q ? pair_q.row_b : pair_q.row_a;
	assign results.out_sample_index = pair_q.idx;
	assign results.out_value        = phase_q ? '0 : pair_q.value;
	assign results.frame_last       = phase_q & pair_q.last;

	a_last_second: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && results.frame_last |-> phase_q && pair_q.two)
		else $error("frame end flagged outside the last-row result");

	a_row_order: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && pair_q.two |-> pair_q.row_b == csf_pkg::ROW_W'(pair_q.row_a + 1'b1))
		else $error("last-row result does not follow the row above");

	a_hold_out: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && !results.ready |=> results.valid && $stable(results.out_row)
			&& $stable(results.out_sample_index) && $stable(results.out_value)
			&& $stable(results.frame_last))
		else $error("waiting result changed before acceptance");

endmodule

>>> rtl/core/cross_sharpen_3x3_filter_unit.sv
// Top level of the cross sharpen filter: position counters, window math, line memories.
// Path: an accepted item's memory read is registered into stage 1, then its results go to the output register.
// Throughput: one item per cycle while results are accepted; last-row items give two results
// through the single output register and so hold it until both are taken.
// Reset: asynchronous, clears counters, pipeline and pixel delay, sets 640x480x1; line
// memories keep their contents and need no clearing pass.
module cross_sharpen_3x3_filter_unit #(
	parameter int MAX_WIDTH    = 2048,
	parameter int MAX_HEIGHT   = 2048,
	parameter int MAX_CHANNELS = 4
) (
	input  logic                        clk,
	input  logic                        arst_n,
	csf_in_if.sink                      samples,
	csf_out_if.source                   results,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [csf_pkg::ADDR_W-1:0]  paddr,
	input  logic [csf_pkg::DATA_W-1:0]  pwdata,
	output logic [csf_pkg::DATA_W-1:0]  prdata,
	output logic                        pready
);
	localparam int DEPTH = MAX_WIDTH * MAX_CHANNELS;
	localparam int AW    = $clog2(DEPTH);
	localparam int SW    = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
	localparam int XW    = AW + csf_pkg::CH_W;

	logic [csf_pkg::CH_W-1:0]   chan;
	logic [csf_pkg::CFG_W-1:0]  row_last;
	logic [AW-1:0]              x_last, x_right;
	logic                       restart;

	logic [AW-1:0]              x_q;
	logic [csf_pkg::CFG_W-1:0]  y_q;
	logic [SW-1:0]              slot_q;
	logic                       in_fire;
	logic [AW-1:0]              right_addr;

	logic                       s1_valid_q;
	logic [csf_pkg::PIX_W-1:0]  sample_s1;
	logic [AW-1:0]              x_s1;
	logic [csf_pkg::CFG_W-1:0]  y_s1;
	logic [SW-1:0]              slot_s1;
	logic                       border_s1, top_s1, bottom_s1, last_s1, has_res_s1;
	logic                       s1_adv;

	logic [csf_pkg::PIX_W-1:0]  pixel_delay_q [MAX_CHANNELS];
	logic [csf_pkg::PIX_W-1:0]  centre, right_px, above, left_px;
	logic [csf_pkg::ACC_W-1:0]  centre_x5, neigh_sum, acc;
	logic [csf_pkg::PIX_W-1:0]  sharp;
	csf_pkg::result_pair_t      pair;
	logic                       emit_ready;

	csf_cfg_regs #(
		.MAX_WIDTH    (MAX_WIDTH),
		.MAX_HEIGHT   (MAX_HEIGHT),
		.MAX_CHANNELS (MAX_CHANNELS)
	) u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.chan     (chan),
		.row_last (row_last),
		.x_last   (x_last),
		.x_right  (x_right),
		.restart  (restart)
	);

	// Stage 0: accept, read both rows and store the sample in the recent row.
	assign samples.ready = ~s1_valid_q | s1_adv;
	assign in_fire       = samples.valid & samples.ready;
	assign right_addr    = AW'(XW'(x_q) + XW'(chan));

	csf_line_mem #(
		.DEPTH (DEPTH)
	) u_mem (
		.clk            (clk),
		.acc_en         (in_fire),
		.acc_addr       (x_q),
		.acc_right_addr (right_addr),
		.acc_sample     (samples.sample_value),
		.older_wr_en    (s1_adv),
		.older_wr_addr  (x_s1),
		.older_wr_data  (centre),
		.centre         (centre),
		.right_px       (right_px),
		.above          (above)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q    <= '0;
			y_q    <= '0;
			slot_q <= '0;
		end else if (restart) begin
			x_q    <= '0;
			y_q    <= '0;
			slot_q <= '0;
		end else if (in_fire) begin
			if (x_q == x_last) begin
				x_q    <= '0;
				slot_q <= '0;
				y_q    <= (y_q == row_last) ? '0 : y_q + csf_pkg::CFG_W'(1);
			end else begin
				x_q    <= x_q + AW'(1);
				slot_q <= (slot_q == SW'(chan - csf_pkg::CH_W'(1))) ? '0 : slot_q + SW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (samples.ready) begin
			s1_valid_q <= in_fire;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			sample_s1  <= samples.sample_value;
			x_s1       <= x_q;
			y_s1       <= y_q;
			slot_s1    <= slot_q;
			border_s1  <= (XW'(x_q) < XW'(chan)) | (x_q >= x_right);
			top_s1     <= (y_q == '0);
			bottom_s1  <= (y_q == row_last);
			last_s1    <= (x_q == x_last);
			has_res_s1 <= (y_q != csf_pkg::CFG_W'(1));
		end
	end

	// Stage 1: memory data arrives; compute, update older row and pixel delay.
	assign s1_adv  = s1_valid_q & (~has_res_s1 | emit_ready);
	assign left_px = pixel_delay_q[slot_s1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_CHANNELS; i++) begin
				pixel_delay_q[i] <= '0;
			end
		end else if (restart) begin
			for (int i = 0; i < MAX_CHANNELS; i++) begin
				pixel_delay_q[i] <= '0;
			end
		end else if (s1_adv) begin
			pixel_delay_q[slot_s1] <= centre;
		end
	end

	assign centre_x5 = csf_pkg::ACC_W'(centre) * csf_pkg::ACC_W'(csf_pkg::CENTRE_GAIN);
	assign neigh_sum = csf_pkg::ACC_W'(left_px) + csf_pkg::ACC_W'(right_px)
		+ csf_pkg::ACC_W'(above) + csf_pkg::ACC_W'(sample_s1);
	assign acc       = centre_x5 - neigh_sum;

	// Clamp: negative goes to zero, anything above the sample range saturates.
	always_comb begin
		priority if (acc[csf_pkg::ACC_W-1]) begin
			sharp = '0;
		end else if (acc[csf_pkg::ACC_W-2:csf_pkg::PIX_W] != '0) begin
			sharp = '1;
		end else begin
			sharp = acc[csf_pkg::PIX_W-1:0];
		end
	end

	always_comb begin
		pair.row_a = top_s1 ? '0 : csf_pkg::ROW_W'(y_s1 - csf_pkg::CFG_W'(1));
		pair.row_b = csf_pkg::ROW_W'(y_s1);
		pair.idx   = csf_pkg::IDX_W'(x_s1);
		pair.value = (border_s1 | top_s1) ? '0 : sharp;
		pair.two   = bottom_s1;
		pair.last  = last_s1;
	end

	csf_emit u_emit (
		.clk        (clk),
		.arst_n     (arst_n),
		.load_valid (s1_valid_q & has_res_s1),
		.load_ready (emit_ready),
		.load_pair  (pair),
		.results    (results)
	);

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		x_q <= x_last && y_q <= row_last)
		else $error("stream position outside the frame");

	a_fill_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> s1_valid_q)
		else $error("accepted item lost before stage 1");

	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q && !s1_adv |=> s1_valid_q && $stable(x_s1) && $stable(centre))
		else $error("stalled stage 1 item changed");

endmodule

>>> tb/cross_sharpen_3x3_filter_unit_tb.sv
// Self-checking bench for the cross sharpen filter: random-idle stream driver, result monitor.
module cross_sharpen_3x3_filter_unit_tb;

	localparam int MAX_WIDTH    = 2048;
	localparam int MAX_HEIGHT   = 2048;
	localparam int MAX_CHANNELS = 4;
	localparam int LINE_DEPTH   = MAX_WIDTH * MAX_CHANNELS;
	localparam int PIX_MAX      = 255;
	localparam int DRAIN_CYCLES = 8;
	localparam int CYCLE_LIMIT  = 600000;
	localparam int RANDOM_ITEMS = 120;
	localparam int WIDE_ITEMS   = 16;
	localparam int REPORT_CAP   = 200;
	localparam logic [1:0] REG_SPARE = 2'd3;

	typedef struct packed {
		logic [csf_pkg::ROW_W-1:0] row;
		logic [csf_pkg::IDX_W-1:0] pos;
		logic [csf_pkg::PIX_W-1:0] value;
		logic                      last;
	} sharp_result_t;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [csf_pkg::ADDR_W-1:0] paddr;
	logic [csf_pkg::DATA_W-1:0] pwdata;
	logic [csf_pkg::DATA_W-1:0] prdata;
	logic pready;

	csf_in_if  samples_if();
	csf_out_if results_if();

	cross_sharpen_3x3_filter_unit #(
		.MAX_WIDTH(MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT),
		.MAX_CHANNELS(MAX_CHANNELS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.samples(samples_if),
		.results(results_if),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	// Predictor state: line memories, per-channel left tap, position, registers.
	logic [csf_pkg::PIX_W-1:0] older_row [0:LINE_DEPTH-1];
	logic [csf_pkg::PIX_W-1:0] recent_row [0:LINE_DEPTH-1];
	logic [csf_pkg::PIX_W-1:0] left_tap [0:MAX_CHANNELS-1];
	int cur_row;
	int cur_pos;
	logic [csf_pkg::CFG_W-1:0] width_reg;
	logic [csf_pkg::CFG_W-1:0] height_reg;
	logic [csf_pkg::CH_W-1:0]  chan_reg;

	logic [csf_pkg::PIX_W-1:0] sample_q [$];
	sharp_result_t sharpened_q [$];
	sharp_result_t observed;
	sharp_result_t oldest;

	int src_idle_pct;
	int snk_idle_pct;
	int items_accepted;
	int results_checked;
	int cfg_writes;
	int error_count;
	int cycle_count;

	function automatic int fit(input int v, input int lo, input int hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	function automatic int row_len();
		return fit(int'(width_reg), csf_pkg::MIN_DIM, MAX_WIDTH)
			* fit(int'(chan_reg), csf_pkg::MIN_CH, MAX_CHANNELS);
	endfunction

	function automatic int frame_size();
		return row_len() * fit(int'(height_reg), csf_pkg::MIN_DIM, MAX_HEIGHT);
	endfunction

	function automatic void push_result(input int row, input int pos, input int value,
		input logic last);
		sharp_result_t r;
		r.row   = row[csf_pkg::ROW_W-1:0];
		r.pos   = pos[csf_pkg::IDX_W-1:0];
		r.value = value[csf_pkg::PIX_W-1:0];
		r.last  = last;
		sharpened_q.push_back(r);
	endfunction

	function automatic void restart_frame();
		cur_row = 0;
		cur_pos = 0;
		for (int i = 0; i < MAX_CHANNELS; i++) left_tap[i] = '0;
	endfunction

	function automatic void cfg_apply(input logic [1:0] idx,
		input logic [csf_pkg::DATA_W-1:0] data);
		case (csf_pkg::reg_idx_t'(idx))
			csf_pkg::REG_WIDTH: begin
				width_reg = data[csf_pkg::CFG_W-1:0];
				restart_frame();
			end
			csf_pkg::REG_HEIGHT: begin
				height_reg = data[csf_pkg::CFG_W-1:0];
				restart_frame();
			end
			csf_pkg::REG_CHANNELS: begin
				chan_reg = data[csf_pkg::CH_W-1:0];
				restart_frame();
			end
			default: begin
			end
		endcase
	endfunction

	function automatic void predict_sharpen(input logic [csf_pkg::PIX_W-1:0] sample);
		int h, c, len, x, y, acc, slot;
		logic [csf_pkg::PIX_W-1:0] above, centre, right, left;
		h = fit(int'(height_reg), csf_pkg::MIN_DIM, MAX_HEIGHT);
		c = fit(int'(chan_reg), csf_pkg::MIN_CH, MAX_CHANNELS);
		len = row_len();
		x = cur_pos;
		y = cur_row;
		if (x >= len) x = len - 1;
		above  = older_row[x];
		centre = recent_row[x];
		right  = (x + c < len) ? recent_row[x + c] : '0;
		slot = x % c;
		left = left_tap[slot];
		left_tap[slot] = centre;
		older_row[x]  = centre;
		recent_row[x] = sample;
		if (y == 0) push_result(0, x, 0, 1'b0);
		if (y >= 2) begin
			acc = 0;
			if (x >= c && x < len - c) begin
				acc = csf_pkg::CENTRE_GAIN * int'(centre) - int'(left) - int'(right)
					- int'(above) - int'(sample);
				acc = fit(acc, 0, PIX_MAX);
			end
			push_result(y - 1, x, acc, 1'b0);
		end
		if (y == h - 1) push_result(y, x, 0, x == len - 1);
		if (x + 1 >= len) begin
			cur_pos = 0;
			cur_row = (y + 1 >= h) ? 0 : y + 1;
		end else begin
			cur_pos = x + 1;
		end
	endfunction

	initial clk = 1'b0;
	always #1 clk = ~clk;

	// Stream driver: hold valid until accepted, predict on acceptance.
	always @(posedge clk) begin
		if (!arst_n) begin
			samples_if.valid <= 1'b0;
		end else begin
			if (samples_if.valid && samples_if.ready) begin
				predict_sharpen(samples_if.sample_value);
				items_accepted++;
			end
			if (!samples_if.valid || samples_if.ready) begin
				if (sample_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
					samples_if.valid <= 1'b1;
					samples_if.sample_value <= sample_q.pop_front();
				end else begin
					samples_if.valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor: compare each accepted result with the oldest prediction.
	always @(posedge clk) begin
		if (!arst_n) begin
			results_if.ready <= 1'b0;
		end else begin
			if (results_if.valid && results_if.ready) begin
				observed.row   = results_if.out_row;
				observed.pos   = results_if.out_sample_index;
				observed.value = results_if.out_value;
				observed.last  = results_if.frame_last;
				if (sharpened_q.size() == 0) begin
					if (error_count < REPORT_CAP)
						$display("%0t: unexpected result row %0d pos %0d value %0d last %0b",
							$time, observed.row, observed.pos, observed.value, observed.last);
					error_count++;
				end else begin
					oldest = sharpened_q.pop_front();
					if (observed !== oldest) begin
						if (error_count < REPORT_CAP)
							$display({"%0t: mismatch expected row %0d pos %0d value %0d last %0b,",
								" got row %0d pos %0d value %0d last %0b"}, $time,
								oldest.row, oldest.pos, oldest.value, oldest.last,
								observed.row, observed.pos, observed.value, observed.last);
						error_count++;
					end
					results_checked++;
				end
			end
			results_if.ready <= ($urandom_range(99) >= snk_idle_pct);
		end
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("%0t: timeout after %0d cycles, %0d results still due", $time, cycle_count,
			sharpened_q.size());
		$display("Regression FAIL");
		$finish;
	end

	task automatic reg_write(input logic [1:0] idx, input logic [csf_pkg::DATA_W-1:0] data);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		cfg_apply(idx, data);
		cfg_writes++;
	endtask

	// Fill bits above the field with junk when asked; the block must ignore them.
	function automatic logic [csf_pkg::DATA_W-1:0] reg_word(input int value, input int bits,
		input bit junk);
		logic [csf_pkg::DATA_W-1:0] d;
		d = junk ? csf_pkg::DATA_W'($urandom) : '0;
		for (int i = 0; i < bits; i++) d[i] = value[i];
		return d;
	endfunction

	task automatic write_config(input int w, input int h, input int c, input bit junk);
		reg_write(csf_pkg::REG_WIDTH, reg_word(w, csf_pkg::CFG_W, junk));
		reg_write(csf_pkg::REG_HEIGHT, reg_word(h, csf_pkg::CFG_W, junk));
		reg_write(csf_pkg::REG_CHANNELS, reg_word(c, csf_pkg::CH_W, junk));
	endtask

	task automatic wait_drained();
		do @(negedge clk);
		while (sample_q.size() != 0 || samples_if.valid || sharpened_q.size() != 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic push_samples(input int n);
		for (int i = 0; i < n; i++) sample_q.push_back(csf_pkg::PIX_W'($urandom));
	endtask

	task automatic run_random(input int quota);
		int sent, fw, fh, fc, n, total;
		sent = 0;
		while (sent < quota) begin
			wait_drained();
			fw = $urandom_range(0, 5);
			fh = $urandom_range(0, 4);
			case ($urandom_range(0, 9))
				0: fc = 0;
				1, 2, 3, 4: fc = 1;
				5, 6: fc = 2;
				7: fc = 3;
				8: fc = 4;
				default: fc = $urandom_range(5, 7);
			endcase
			write_config(fw, fh, fc, $urandom_range(0, 3) == 0);
			total = frame_size();
			repeat ($urandom_range(1, 2)) begin
				n = ($urandom_range(0, 5) == 0) ? $urandom_range(1, total - 1) : total;
				if ($urandom_range(0, 3) == 0) begin
					// Stall mid-frame, poke the spare address, then finish the frame.
					push_samples(n / 2);
					wait_drained();
					reg_write(REG_SPARE, csf_pkg::DATA_W'($urandom));
					push_samples(n - n / 2);
				end else begin
					push_samples(n);
				end
				sent += n;
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		samples_if.valid = 1'b0;
		samples_if.sample_value = '0;
		results_if.ready = 1'b0;
		items_accepted = 0;
		results_checked = 0;
		cfg_writes = 0;
		error_count = 0;
		for (int i = 0; i < LINE_DEPTH; i++) begin
			older_row[i] = '0;
			recent_row[i] = '0;
		end
		width_reg  = csf_pkg::CFG_W'(csf_pkg::WIDTH_RST);
		height_reg = csf_pkg::CFG_W'(csf_pkg::HEIGHT_RST);
		chan_reg   = csf_pkg::CH_W'(csf_pkg::CHANNELS_RST);
		restart_frame();
		src_idle_pct = 17;
		snk_idle_pct = 58;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Reset geometry: start of row 0.
		for (int i = 0; i < 8; i++) sample_q.push_back(i[0] ? csf_pkg::PIX_W'(PIX_MAX) : '0);
		wait_drained();

		// Smallest frame: lone bright centre clamps high, then lone dark centre clamps low.
		write_config(csf_pkg::MIN_DIM, csf_pkg::MIN_DIM, csf_pkg::MIN_CH, 1'b0);
		for (int i = 0; i < 9; i++)
			sample_q.push_back((i == 4) ? csf_pkg::PIX_W'(PIX_MAX) : '0);
		for (int i = 0; i < 9; i++)
			sample_q.push_back((i == 4) ? '0 : csf_pkg::PIX_W'(PIX_MAX));

		for (int phase = 0; phase < 3; phase++) begin
			wait_drained();
			src_idle_pct = (phase == 0) ? 17 : ((phase == 1) ? 58 : 0);
			snk_idle_pct = (phase == 0) ? 58 : ((phase == 1) ? 17 : 0);
			run_random(RANDOM_ITEMS / 3);
			wait_drained();
			if (phase == 1) begin
				// Width saturates to the maximum; start of row 0.
				write_config(4095, csf_pkg::MIN_DIM, csf_pkg::MIN_CH, 1'b0);
				push_samples(WIDE_ITEMS);
			end else if (phase == 2) begin
				// Widest row at four channels, height saturated; start of row 0.
				write_config(MAX_WIDTH, 4095, MAX_CHANNELS, 1'b0);
				push_samples(WIDE_ITEMS);
			end
		end

		wait_drained();
		$display("Covered %0d items and %0d results across %0d register writes,",
			items_accepted, results_checked, cfg_writes);
		$display("from 3x3 frames up to 2048-pixel rows, 1-4 channels, three idle profiles.");
		if (error_count == 0) begin
			$display("Regression PASS");
		end else begin
			$display("%0d mismatches", error_count);
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

>>> filelist.f
rtl/core/csf_pkg.sv
rtl/core/csf_in_if.sv
rtl/core/csf_out_if.sv
rtl/core/csf_cfg_regs.sv
rtl/core/csf_line_mem.sv
rtl/core/csf_emit.sv
rtl/core/cross_sharpen_3x3_filter_unit.sv
tb/cross_sharpen_3x3_filter_unit_tb.sv
